/* rtl/core/slru_pkg.sv */
// Shared constants, types and helpers for the segmented LRU replacement block.
package slru_pkg;

  localparam int NUM_SETS   = 64;
  localparam int WAYS       = 8;
  localparam int STAMP_BITS = 48;
  localparam int BLOCKS     = NUM_SETS * WAYS;

  localparam int BLK_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int IDX_W  = $clog2(BLOCKS + 1);
  localparam int SIZE_W = 10;

  // Field widths on the streams (fixed by the item formats)
  localparam int CMD_W   = 2;
  localparam int SET_W   = 6;
  localparam int WAY_W   = 3;
  localparam int DBLK_W  = 9;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 16;
  localparam int APB_AW  = 2;
  localparam int APB_DW  = 32;

  // Register map
  localparam logic [APB_AW-1:0] REG_PROTECTED_SIZE = APB_AW'(0);

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam logic [SIZE_W-1:0]     SIZE_RESET = SIZE_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_INVALIDATE = 2'd0,
    CMD_INSERT     = 2'd1,
    CMD_TOUCH      = 2'd2,
    CMD_VICTIM     = 2'd3
  } slru_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLK,
    ST_SCAN,
    ST_PROMO,
    ST_VSCAN,
    ST_DONE
  } slru_state_t;

  typedef struct packed {
    logic                  seg;
    logic [STAMP_BITS-1:0] stamp;
  } slru_entry_t;

  // Flat block number of a set and way
  function automatic logic [BLK_W-1:0] slru_blk(input int unsigned s, input int unsigned w);
    logic [31:0] b;
    b = s * WAYS + w;
    return b[BLK_W-1:0];
  endfunction

endpackage

/* rtl/core/segmented_lru_replacement.sv */
// Segmented LRU replacement state with a cache-wide protected segment.
//
// Every block's segment bit and last-use stamp live in one single-port-read,
// single-port-write memory of 512 entries. After reset the block runs a
// clearing pass over every entry before it takes its first item (configuration
// writes are taken throughout). One item at a time is processed: invalidate,
// insert and a touch that needs no demotion pass through ST_BLK to ST_DONE;
// a victim search reads the eight ways of the set one per cycle; a touch that
// promotes into a full protected segment reads every block's entry once, one
// per cycle, to find the oldest protected block, then writes the promoted
// block in ST_PROMO. The result sits in an output register, so the next
// item is accepted while a result still waits to be taken.
module segmented_lru_replacement
  import slru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: command[1:0], set_index[7:2], way[10:8], zero[15:11]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // out_tdata: victim_way[2:0], victim_found[3], demoted_valid[4],
  //            demoted_block[13:5], zero[15:14]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Control registers
  slru_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [SIZE_W-1:0]       size_r, size_nxt;
  logic [SIZE_W-1:0]       cnt_r, cnt_nxt;
  logic [STAMP_BITS-1:0]   ctr_r, ctr_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Item payload registers
  slru_cmd_t               cmd_r, cmd_nxt;
  logic [SET_W-1:0]        set_r, set_nxt;
  logic [BLK_W-1:0]        blk_r, blk_nxt;
  logic [STAMP_BITS-1:0]   now_r, now_nxt;
  logic                    best_found_r, best_found_nxt;
  logic [STAMP_BITS-1:0]   best_stamp_r, best_stamp_nxt;
  logic [BLK_W-1:0]        best_idx_r, best_idx_nxt;
  logic                    dem_r, dem_nxt;
  logic [OUT_W-1:0]        out_data_r, out_data_nxt;

  // Memory
  slru_entry_t             mem_r [BLOCKS];
  slru_entry_t             rd_q_r;
  logic                    rd_en;
  logic [BLK_W-1:0]        rd_addr;
  logic                    we;
  logic [BLK_W-1:0]        wr_addr;
  slru_entry_t             wr_data;

  // Decoded input item
  slru_cmd_t               in_cmd;
  logic [SET_W-1:0]        in_set;
  logic [WAY_W-1:0]        in_way;
  logic                    in_acc;
  logic                    in_ok;

  logic                    cfg_wr;
  logic                    out_free;
  logic                    scan_last;
  logic                    vic_last;
  logic                    promote;
  logic                    need_scan;
  logic                    take_prot;
  logic                    take_prob;
  logic [BLK_W-1:0]        prev_idx;
  logic                    fin_found;
  logic [BLK_W-1:0]        fin_idx;
  logic [STAMP_BITS-1:0]   fin_stamp;
  logic [STAMP_BITS-1:0]   ctr_inc;

  assign in_cmd = slru_cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_set = in_tdata[CMD_W +: SET_W];
  assign in_way = in_tdata[CMD_W+SET_W +: WAY_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_ok     = (32'(in_set) < NUM_SETS) && ((in_cmd == CMD_VICTIM) || (32'(in_way) < WAYS));

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_PROTECTED_SIZE);
  assign cfg_prdata = APB_DW'(size_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign scan_last = (idx_r == IDX_W'(BLOCKS));
  assign vic_last  = (idx_r == IDX_W'(WAYS));
  assign promote   = !rd_q_r.seg && (size_r != '0);
  assign need_scan = promote && !(cnt_r < size_r);
  assign prev_idx  = BLK_W'(idx_r - 1'b1);
  assign ctr_inc   = (ctr_r == STAMP_MAX) ? ctr_r : ctr_r + 1'b1;

  // Candidate from the entry read in the previous cycle
  assign take_prot = (idx_r != '0) && rd_q_r.seg &&
                     (!best_found_r || (rd_q_r.stamp < best_stamp_r));
  assign take_prob = (idx_r != '0) && !rd_q_r.seg &&
                     (!best_found_r || (rd_q_r.stamp < best_stamp_r));
  assign fin_found = best_found_r || take_prot;
  assign fin_idx   = take_prot ? prev_idx : best_idx_r;
  assign fin_stamp = take_prot ? rd_q_r.stamp : best_stamp_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (idx_r == IDX_W'(BLOCKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          priority if (!in_ok)                state_nxt = ST_DONE;
          else if (in_cmd == CMD_VICTIM)      state_nxt = ST_VSCAN;
          else                                state_nxt = ST_BLK;
        end
      end
      ST_BLK: begin
        state_nxt = ((cmd_r == CMD_TOUCH) && need_scan) ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_PROMO;
      end
      ST_PROMO: state_nxt = ST_DONE;
      ST_VSCAN: begin
        if (vic_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_nxt        = idx_r;
    size_nxt       = cfg_wr ? cfg_pwdata[SIZE_W-1:0] : size_r;
    cnt_nxt        = cnt_r;
    ctr_nxt        = ctr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmd_nxt        = cmd_r;
    set_nxt        = set_r;
    blk_nxt        = blk_r;
    now_nxt        = now_r;
    best_found_nxt = best_found_r;
    best_stamp_nxt = best_stamp_r;
    best_idx_nxt   = best_idx_r;
    dem_nxt        = dem_r;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    rd_addr        = slru_blk(32'(in_set), 32'(in_way));
    we             = 1'b0;
    wr_addr        = blk_r;
    wr_data        = '0;

    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = BLK_W'(idx_r);
        idx_nxt = idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_cmd;
          set_nxt        = in_set;
          blk_nxt        = slru_blk(32'(in_set), 32'(in_way));
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          best_idx_nxt   = '0;
          dem_nxt        = 1'b0;
          rd_en          = in_ok && (in_cmd != CMD_VICTIM);
        end
      end
      ST_BLK: begin
        unique case (cmd_r)
          CMD_INVALIDATE, CMD_INSERT: begin
            we      = 1'b1;
            wr_data = '{seg: 1'b0, stamp: (cmd_r == CMD_INSERT) ? ctr_r : '0};
            if (rd_q_r.seg && (cnt_r != '0)) cnt_nxt = cnt_r - 1'b1;
            if (cmd_r == CMD_INSERT) ctr_nxt = ctr_inc;
          end
          CMD_TOUCH: begin
            ctr_nxt = ctr_inc;
            now_nxt = ctr_r;
            priority if (!promote) begin
              we      = 1'b1;
              wr_data = '{seg: rd_q_r.seg, stamp: ctr_r};
            end else if (!need_scan) begin
              we      = 1'b1;
              wr_data = '{seg: 1'b1, stamp: ctr_r};
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              // full segment: hold the write until the oldest block is known
              we = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (!scan_last) begin
          rd_en   = 1'b1;
          rd_addr = BLK_W'(idx_r);
          idx_nxt = idx_r + 1'b1;
          if (take_prot) begin
            best_found_nxt = 1'b1;
            best_stamp_nxt = rd_q_r.stamp;
            best_idx_nxt   = prev_idx;
          end
        end else if (fin_found) begin
          // demote the oldest protected block; the count stays as it is
          we           = 1'b1;
          wr_addr      = fin_idx;
          wr_data      = '{seg: 1'b0, stamp: fin_stamp};
          dem_nxt      = 1'b1;
          best_idx_nxt = fin_idx;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PROMO: begin
        we      = 1'b1;
        wr_data = '{seg: 1'b1, stamp: now_r};
      end
      ST_VSCAN: begin
        if (!vic_last) begin
          rd_en   = 1'b1;
          rd_addr = slru_blk(32'(set_r), 32'(idx_r));
          idx_nxt = idx_r + 1'b1;
        end
        if (take_prob) begin
          best_found_nxt = 1'b1;
          best_stamp_nxt = rd_q_r.stamp;
          best_idx_nxt   = prev_idx;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_VICTIM) begin
            out_data_nxt = OUT_W'({best_found_r, WAY_W'(best_idx_r)});
          end else begin
            out_data_nxt = OUT_W'({DBLK_W'(best_idx_r), dem_r, 1'b0, WAY_W'(0)});
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      size_r      <= SIZE_RESET;
      cnt_r       <= '0;
      ctr_r       <= STAMP_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      size_r      <= size_nxt;
      cnt_r       <= cnt_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    set_r        <= set_nxt;
    blk_r        <= blk_nxt;
    now_r        <= now_nxt;
    best_found_r <= best_found_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_idx_r   <= best_idx_nxt;
    dem_r        <= dem_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Block state memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem_r[rd_addr];
  end

endmodule

/* rtl/core/slru_checker.sv */
// Port-level checks for the segmented LRU replacement block, bound to the top level.
module slru_checker
  import slru_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item dropped or changed while stalled");

  // No way number without a found victim
  a_victim_way: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> (out_tdata[2:0] == '0))
    else $error("victim way set without a found victim");

  // Demotion and victim report never share an item
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[4]))
    else $error("victim and demotion reported together");

  // Demoted block is zero when no demotion
  a_dem_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> (out_tdata[13:5] == '0))
    else $error("demoted block set without a demotion");

  // An accepted item cannot bring its result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind segmented_lru_replacement slru_checker u_slru_checker (.*);
